[sv/ppc_pkg.sv]
`timescale 1ns / 1ps

package ppc_pkg;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 12;

  localparam logic [CountW-1:0] CountMax     = {CountW{1'b1}};
  localparam logic [CountW-1:0] MaxLenReset  = CountW'(240);
  localparam logic [CharW-1:0]  CtrlLimit    = CharW'(32);

  // Characters the checker looks for
  localparam logic [CharW-1:0] ChSlash     = 8'h2F;
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChColon     = 8'h3A;
  localparam logic [CharW-1:0] ChDot       = 8'h2E;
  localparam logic [CharW-1:0] ChLowerP    = 8'h70;
  localparam logic [CharW-1:0] ChLowerK    = 8'h6B;
  localparam logic [CharW-1:0] ChDigit3    = 8'h33;
  localparam logic [CharW-1:0] ChUpperA    = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ    = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA    = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ    = 8'h7A;
  localparam logic [CharW-1:0] CaseOffset  = 8'h20;

  // Kind of the component currently being collected
  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_DOT    = 2'd1,
    KIND_DOTDOT = 2'd2,
    KIND_TEXT   = 2'd3
  } comp_kind_e;

  // Extension matcher, one-hot: progress through ".pk3" after the last dot
  typedef enum logic [5:0] {
    EXT_NONE = 6'b000001,
    EXT_DOT  = 6'b000010,
    EXT_P    = 6'b000100,
    EXT_PK   = 6'b001000,
    EXT_PK3  = 6'b010000,
    EXT_MISS = 6'b100000
  } ext_state_e;

  // One input beat
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             char_valid;
    logic             end_of_path;
  } item_t;

  // One result beat
  typedef struct packed {
    logic allowed_package;
    logic safe_relative;
  } verdict_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) ? c + CaseOffset : c;
  endfunction

endpackage

[sv/ppc_path_state.sv]
`timescale 1ns / 1ps

module ppc_path_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  ppc_pkg::item_t              item_i,
  input  logic [ppc_pkg::CountW-1:0]  max_len_i,
  output ppc_pkg::verdict_t           verdict_o
);
  import ppc_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_n;
  logic              failed_q, failed_d, failed_n;
  logic              first_letter_q, first_letter_d, first_letter_n;
  comp_kind_e        kind_q, kind_d, kind_n;
  ext_state_e        ext_q, ext_d, ext_n;

  logic [CharW-1:0] c;
  logic [CharW-1:0] lower;
  logic             is_sep;
  logic             safe;

  assign c      = item_i.char_code;
  assign lower  = to_lower(c);
  assign is_sep = (c == ChSlash) || (c == ChBackslash);

  // Path state after taking the byte of this beat, if it carries one.
  always_comb begin
    cnt_n          = cnt_q;
    failed_n       = failed_q;
    first_letter_n = first_letter_q;
    kind_n         = kind_q;
    ext_n          = ext_q;
    if (item_i.char_valid) begin
      // Leading separator and drive prefix checks.
      if (cnt_q == '0) begin
        if (is_sep) begin
          failed_n = 1'b1;
        end
        first_letter_n = is_letter(c);
      end else if (cnt_q == CountW'(1)) begin
        if (first_letter_q && (c == ChColon)) begin
          failed_n = 1'b1;
        end
      end

      // Component tracking; a separator closes the current component.
      if (is_sep) begin
        if (kind_q != KIND_TEXT) begin
          failed_n = 1'b1;
        end
        kind_n = KIND_EMPTY;
      end else begin
        if (c < CtrlLimit) begin
          failed_n = 1'b1;
        end
        if ((c == ChDot) && (kind_q != KIND_TEXT)) begin
          kind_n = comp_kind_e'(kind_q + 2'd1);
        end else begin
          kind_n = KIND_TEXT;
        end
      end

      // Extension matcher restarts at every dot.
      if (c == ChDot) begin
        ext_n = EXT_DOT;
      end else begin
        case (ext_q)
          EXT_NONE: ext_n = EXT_NONE;
          EXT_DOT:  ext_n = (lower == ChLowerP) ? EXT_P : EXT_MISS;
          EXT_P:    ext_n = (lower == ChLowerK) ? EXT_PK : EXT_MISS;
          EXT_PK:   ext_n = (c == ChDigit3) ? EXT_PK3 : EXT_MISS;
          default:  ext_n = EXT_MISS;
        endcase
      end

      // Saturating length count.
      if (cnt_q != CountMax) begin
        cnt_n = cnt_q + CountW'(1);
      end
    end
  end

  // Verdict from the state that includes the final byte.
  assign safe = !failed_n && (cnt_n != '0) && (cnt_n < max_len_i) && (kind_n == KIND_TEXT);
  assign verdict_o.safe_relative   = safe;
  assign verdict_o.allowed_package = safe && (ext_n == EXT_PK3);

  // End of path clears everything for the next path.
  always_comb begin
    cnt_d          = cnt_q;
    failed_d       = failed_q;
    first_letter_d = first_letter_q;
    kind_d         = kind_q;
    ext_d          = ext_q;
    if (take_i) begin
      if (item_i.end_of_path) begin
        cnt_d          = '0;
        failed_d       = 1'b0;
        first_letter_d = 1'b0;
        kind_d         = KIND_EMPTY;
        ext_d          = EXT_NONE;
      end else begin
        cnt_d          = cnt_n;
        failed_d       = failed_n;
        first_letter_d = first_letter_n;
        kind_d         = kind_n;
        ext_d          = ext_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      failed_q       <= 1'b0;
      first_letter_q <= 1'b0;
      kind_q         <= KIND_EMPTY;
      ext_q          <= EXT_NONE;
    end else begin
      cnt_q          <= cnt_d;
      failed_q       <= failed_d;
      first_letter_q <= first_letter_d;
      kind_q         <= kind_d;
      ext_q          <= ext_d;
    end
  end

  // A path that ends leaves a cleared state behind.
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.end_of_path |=> (cnt_q == '0) && !failed_q)
    else $error("path state not cleared after end of path");

  // No byte seen means no failure, empty component and no dot.
  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !failed_q && (kind_q == KIND_EMPTY) && (ext_q == EXT_NONE))
    else $error("state present with zero byte count");

  // A package is always a safe path.
  a_allowed_is_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_o.allowed_package |-> verdict_o.safe_relative)
    else $error("allowed package on an unsafe path");

endmodule

[sv/ppc_out_reg.sv]
`timescale 1ns / 1ps

module ppc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ppc_pkg::verdict_t verdict_i,
  input  logic              ready_i,
  output logic              valid_o,
  output ppc_pkg::verdict_t verdict_o,
  output logic              free_o
);
  import ppc_pkg::*;

  logic     valid_q, valid_d;
  verdict_t verdict_q;

  // The register can take a new result when empty or when drained this cycle.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;

endmodule

[sv/package_path_checker_unit.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Beat contents
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | tdata: char_code; tuser: char_valid; tlast: end_of_path
// m_axis    | out       | tdata: safe_relative, allowed_package, zero padding
// cfg       | in        | cfg_data_i: max_path_length
//
// One byte is accepted per cycle unless input stalls; a verdict for the beat
// with tlast comes through the input register and then the result register.
// Reset clears the path state and sets max_path_length to 240.
// A stalled result holds the result register; the input register still drains
// beats without tlast, so input stalls only when a final beat waits on it.
// The configuration channel is always ready.

module package_path_checker_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Path bytes
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
  input  logic                         s_axis_tuser,   // [0] char_valid
  input  logic                         s_axis_tlast,   // end_of_path
  // Verdicts
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [0] safe_relative,
                                                       // [1] allowed_package
  // Length limit register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ppc_pkg::CountW-1:0]   cfg_data_i
);
  import ppc_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  item_t             s1_q;
  logic              s1_advance;
  logic              s_fire;
  logic              out_free;
  logic [CountW-1:0] max_len_q;
  verdict_t          verdict;
  verdict_t          out_verdict;

  // Length limit register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Input register: a beat moves on unless it ends a path and no result slot is free.
  assign s1_advance    = s1_valid_q && (!s1_q.end_of_path || out_free);
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_q.char_code   <= s_axis_tdata;
      s1_q.char_valid  <= s_axis_tuser;
      s1_q.end_of_path <= s_axis_tlast;
    end
  end

  // Path state and verdict logic.
  ppc_path_state u_path_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (s1_advance),
    .item_i    (s1_q),
    .max_len_i (max_len_q),
    .verdict_o (verdict)
  );

  // Result register.
  ppc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (s1_advance && s1_q.end_of_path),
    .verdict_i (verdict),
    .ready_i   (m_axis_tready),
    .valid_o   (m_axis_tvalid),
    .verdict_o (out_verdict),
    .free_o    (out_free)
  );

  assign m_axis_tdata = {6'b0, out_verdict.allowed_package, out_verdict.safe_relative};

  // Input backpressure only comes from a final beat waiting on the result register.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_q.end_of_path && m_axis_tvalid)
    else $error("input stalled without a blocked final beat");

  // A blocked final beat stays in the input register unchanged.
  a_final_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.end_of_path && !out_free |=> s1_valid_q && $stable(s1_q))
    else $error("blocked final beat lost");

endmodule
